### hw/rtl/sns_pkg.sv
package sns_pkg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_FIRE,
        OP_MUL_KV,
        OP_ADD_LIN,
        OP_MUL_V,
        OP_ADD_OFF,
        OP_SUB_U,
        OP_ADD_CUR,
        OP_MUL_STEP,
        OP_ADD_V,
        OP_MUL_BV,
        OP_MUL_A,
        OP_ADD_U,
        OP_WB
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic integrator;
    } status_t;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_NEURON_KIND = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXCITATORY  = 1'd1;

    localparam logic [1:0] KIND_TONIC      = 2'd0;
    localparam logic [1:0] KIND_PHASIC     = 2'd1;
    localparam logic [1:0] KIND_INTEGRATOR = 2'd2;
    localparam logic [1:0] KIND_GENERIC    = 2'd3;

    localparam logic signed [31:0] V_RESET = -32'sd4587520;
    localparam logic signed [31:0] U_RESET = -32'sd917504;

endpackage

### hw/rtl/sns_ctrl.sv
module sns_ctrl
    import sns_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    in_action,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRE,
        S_EULER,
        S_RECOV,
        S_WB
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] op_idx_reg;
    logic [2:0] op_idx_next;
    logic [1:0] step_reg;
    logic [1:0] step_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       slot_free;
    logic [1:0] last_step;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign last_step = status.integrator ? 2'd3 : 2'd1;

    always_comb
    begin
        state_next     = state_reg;
        op_idx_next    = op_idx_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_idx_next = 3'd0;
                    step_next   = 2'd0;
                    if (in_action)
                    begin
                        cmd.op     = OP_LOAD;
                        state_next = S_FIRE;
                    end
                    else
                    begin
                        cmd.op     = OP_INIT;
                        state_next = S_WB;
                    end
                end
            end
            S_FIRE:
            begin
                cmd.op     = OP_FIRE;
                state_next = S_EULER;
            end
            S_EULER:
            begin
                unique case (op_idx_reg)
                    3'd0: cmd.op = OP_MUL_KV;
                    3'd1: cmd.op = OP_ADD_LIN;
                    3'd2: cmd.op = OP_MUL_V;
                    3'd3: cmd.op = OP_ADD_OFF;
                    3'd4: cmd.op = OP_SUB_U;
                    3'd5: cmd.op = OP_ADD_CUR;
                    3'd6: cmd.op = OP_MUL_STEP;
                    default: cmd.op = OP_ADD_V;
                endcase
                op_idx_next = op_idx_reg + 3'd1;
                if (op_idx_reg == 3'd7)
                begin
                    if (step_reg == last_step)
                    begin
                        state_next = S_RECOV;
                    end
                    else
                    begin
                        step_next = step_reg + 2'd1;
                    end
                end
            end
            S_RECOV:
            begin
                unique case (op_idx_reg[1:0])
                    2'd0: cmd.op = OP_MUL_BV;
                    2'd1: cmd.op = OP_SUB_U;
                    2'd2: cmd.op = OP_MUL_A;
                    default: cmd.op = OP_ADD_U;
                endcase
                op_idx_next = op_idx_reg + 3'd1;
                if (op_idx_reg[1:0] == 2'd3)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                if (slot_free)
                begin
                    cmd.op         = OP_WB;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_idx_reg    <= 3'd0;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_idx_reg    <= op_idx_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/sns_datapath.sv
module sns_datapath
    import sns_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic signed [31:0]     current,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   spiked,
    output logic signed [31:0]     membrane,
    output logic signed [31:0]     recovery
);

    localparam logic signed [31:0] TH_30     = 32'sd1966080;
    localparam logic signed [31:0] K_004     = 32'sd2621;
    localparam logic signed [31:0] K_5       = 32'sd327680;
    localparam logic signed [31:0] K_140     = 32'sd9175040;
    localparam logic signed [31:0] K_4_1     = 32'sd268698;
    localparam logic signed [31:0] K_108     = 32'sd7077888;
    localparam logic signed [31:0] K_HALF    = 32'sd32768;
    localparam logic signed [31:0] K_QUARTER = 32'sd16384;
    localparam logic signed [31:0] K_002     = 32'sd1311;
    localparam logic signed [31:0] K_01      = 32'sd6554;
    localparam logic signed [31:0] K_02      = 32'sd13107;
    localparam logic signed [31:0] K_025     = 32'sd16384;
    localparam logic signed [31:0] C_65      = -32'sd4259840;
    localparam logic signed [31:0] C_55      = -32'sd3604480;
    localparam logic signed [31:0] D_6       = 32'sd393216;
    localparam logic signed [31:0] D_2       = 32'sd131072;

    function automatic logic signed [31:0] sat_prod(input logic signed [47:0] x);
        logic signed [31:0] r;
        if (x > 48'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (x < -48'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_sum(input logic signed [33:0] x);
        logic signed [31:0] r;
        if (x > 34'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (x < -34'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    logic [1:0]         kind_reg;
    logic               exc_reg;
    logic signed [31:0] v_reg;
    logic signed [31:0] u_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] cur_reg;
    logic               fired_reg;
    logic               spiked_reg;
    logic signed [31:0] membrane_reg;
    logic signed [31:0] recovery_reg;

    logic signed [31:0] p_a;
    logic signed [31:0] p_b;
    logic signed [31:0] p_c;
    logic signed [31:0] p_d;
    logic signed [31:0] p_lin;
    logic signed [31:0] p_off;
    logic signed [31:0] p_step;
    logic signed [31:0] init_v;
    logic signed [31:0] init_u;
    logic               integ;
    logic               slow_generic;

    logic signed [31:0] mul_x;
    logic signed [31:0] mul_y;
    logic signed [63:0] prod;
    logic signed [31:0] mul_res;
    logic signed [31:0] add_x;
    logic signed [31:0] add_y;
    logic               add_sub;
    logic signed [33:0] add_y_ext;
    logic signed [33:0] sum;
    logic signed [31:0] add_res;

    assign integ          = (kind_reg == KIND_INTEGRATOR);
    assign slow_generic   = (kind_reg == KIND_GENERIC) && !exc_reg;
    assign status.integrator = integ;

    assign p_a    = slow_generic ? K_01 : K_002;
    assign p_d    = slow_generic ? D_2 : D_6;
    assign p_c    = integ ? C_55 : C_65;
    assign p_lin  = integ ? K_4_1 : K_5;
    assign p_off  = integ ? K_108 : K_140;
    assign p_step = integ ? K_QUARTER : K_HALF;

    always_comb
    begin
        unique case (kind_reg)
            KIND_TONIC:
            begin
                p_b    = K_02;
                init_v = -32'sd4587520;
                init_u = -32'sd917504;
            end
            KIND_PHASIC:
            begin
                p_b    = K_025;
                init_v = -32'sd4194304;
                init_u = -32'sd1048576;
            end
            KIND_INTEGRATOR:
            begin
                p_b    = -K_01;
                init_v = -32'sd3932160;
                init_u = 32'sd393216;
            end
            default:
            begin
                p_b    = K_025;
                init_v = -32'sd4194304;
                init_u = -32'sd838861;
            end
        endcase
    end

    always_comb
    begin
        mul_x   = K_004;
        mul_y   = v_reg;
        add_x   = acc_reg;
        add_y   = p_lin;
        add_sub = 1'b0;
        case (cmd.op)
            OP_MUL_V:
            begin
                mul_x = acc_reg;
            end
            OP_MUL_STEP:
            begin
                mul_x = p_step;
                mul_y = acc_reg;
            end
            OP_MUL_BV:
            begin
                mul_x = p_b;
            end
            OP_MUL_A:
            begin
                mul_x = p_a;
                mul_y = acc_reg;
            end
            OP_ADD_OFF:
            begin
                add_y = p_off;
            end
            OP_SUB_U:
            begin
                add_y   = u_reg;
                add_sub = 1'b1;
            end
            OP_ADD_CUR:
            begin
                add_y = cur_reg;
            end
            OP_ADD_V:
            begin
                add_x = v_reg;
                add_y = acc_reg;
            end
            OP_ADD_U:
            begin
                add_x = u_reg;
                add_y = acc_reg;
            end
            OP_FIRE:
            begin
                add_x = u_reg;
                add_y = p_d;
            end
            default:
            begin
                mul_x = K_004;
            end
        endcase
    end

    assign prod      = mul_x * mul_y;
    assign mul_res   = sat_prod(prod[63:16]);
    assign add_y_ext = add_sub ? -{{2{add_y[31]}}, add_y} : {{2{add_y[31]}}, add_y};
    assign sum       = {{2{add_x[31]}}, add_x} + add_y_ext;
    assign add_res   = sat_sum(sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= KIND_TONIC;
            exc_reg  <= 1'b1;
            v_reg    <= V_RESET;
            u_reg    <= U_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_NEURON_KIND: kind_reg <= cfg_data;
                    CFG_EXCITATORY:  exc_reg  <= cfg_data[0];
                    default:         kind_reg <= kind_reg;
                endcase
            end
            case (cmd.op)
                OP_INIT:
                begin
                    v_reg <= init_v;
                    u_reg <= init_u;
                end
                OP_FIRE:
                begin
                    if (v_reg >= TH_30)
                    begin
                        v_reg <= p_c;
                        u_reg <= add_res;
                    end
                end
                OP_ADD_V: v_reg <= add_res;
                OP_ADD_U: u_reg <= add_res;
                default:  v_reg <= v_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_INIT:     fired_reg <= 1'b0;
            OP_LOAD:
            begin
                cur_reg   <= current;
                fired_reg <= 1'b0;
            end
            OP_FIRE:     fired_reg <= (v_reg >= TH_30);
            OP_MUL_KV,
            OP_MUL_V,
            OP_MUL_STEP,
            OP_MUL_BV,
            OP_MUL_A:    acc_reg <= mul_res;
            OP_ADD_LIN,
            OP_ADD_OFF,
            OP_SUB_U,
            OP_ADD_CUR:  acc_reg <= add_res;
            OP_WB:
            begin
                spiked_reg   <= fired_reg;
                membrane_reg <= v_reg;
                recovery_reg <= u_reg;
            end
            default:     acc_reg <= acc_reg;
        endcase
    end

    assign spiked   = spiked_reg;
    assign membrane = membrane_reg;
    assign recovery = recovery_reg;

endmodule

### hw/rtl/spiking_neuron_step.sv
// Channel   Direction  Handshake                     Contents
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser: action; tdata: current
// m_axis    out        m_axis_tvalid/m_axis_tready   tuser: spiked; tdata: membrane, recovery
// cfg       in         cfg_valid/cfg_ready           cfg_index, cfg_data
//
// A tick request runs one load, one spike test, eight operations per Euler step on one shared
// multiplier and one saturating adder, four for the recovery update and one write-back.
// An init request loads the initial state of the kind, then writes back.
// Requests are handled one at a time.
// The result register frees the core, so the next request is taken while a result waits.
// Reset loads the tonic state and the default configuration at once.
module spiking_neuron_step
    import sns_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,   // [31:0] current
    input  logic                   s_axis_tuser,   // [0] action
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [63:0]            m_axis_tdata,   // [31:0] membrane, [63:32] recovery
    output logic                   m_axis_tuser,   // [0] spiked
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cmd_t               cmd;
    status_t            status;
    logic signed [31:0] membrane;
    logic signed [31:0] recovery;

    assign cfg_ready = 1'b1;

    sns_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    sns_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .current   ($signed(s_axis_tdata)),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .spiked    (m_axis_tuser),
        .membrane  (membrane),
        .recovery  (recovery)
    );

    assign m_axis_tdata = {recovery, membrane};

endmodule

### hw/rtl/sns_checker.sv
module sns_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A waiting result does not change.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // The core works on one request at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while the core is busy");

    // A new result is only produced by a request in progress.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a request in progress");

endmodule

bind spiking_neuron_step sns_checker u_sns_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### bench/spiking_neuron_step_tb.sv
module spiking_neuron_step_tb;
    import sns_pkg::*;

    localparam int     Q           = 65536;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam longint S32_MAX     = 64'sd2147483647;
    localparam longint S32_MIN     = -64'sd2147483648;
    localparam longint Q_ONE       = 65536;
    localparam longint FIRE_LEVEL  = 30 * 65536;
    localparam longint K_004       = 2621;
    localparam longint K_5         = 5 * 65536;
    localparam longint K_140       = 140 * 65536;
    localparam longint K_4_1       = 268698;
    localparam longint K_108       = 108 * 65536;
    localparam longint K_HALF      = 32768;
    localparam longint K_QUARTER   = 16384;
    localparam longint K_002       = 1311;
    localparam longint K_01        = 6554;
    localparam longint K_02        = 13107;
    localparam logic   ACT_INIT    = 1'b0;
    localparam logic   ACT_TICK    = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] current;
    } neuron_req_t;

    typedef struct packed {
        logic        spiked;
        logic [31:0] membrane;
        logic [31:0] recovery;
    } neuron_out_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } reg_write_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [31:0]            s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [63:0]            m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    neuron_req_t queued_requests[$];
    neuron_out_t due_outputs[$];
    reg_write_t  queued_writes[$];

    longint   model_v = longint'(V_RESET);
    longint   model_u = longint'(U_RESET);
    logic [1:0] model_kind = KIND_TONIC;
    logic     model_exc = 1'b1;

    int  requests_issued = 0;
    int  outputs_checked = 0;
    int  writes_issued = 0;
    int  writes_applied = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  src_gap = 0;
    int  sink_gap = 0;
    bit  idle_on = 1'b1;

    spiking_neuron_step i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp32(longint x);
        if (x > S32_MAX)
            return S32_MAX;
        if (x < S32_MIN)
            return S32_MIN;
        return x;
    endfunction

    function automatic longint qmul(longint x, longint y);
        longint p;
        p = x * y;
        return clamp32(p >>> 16);
    endfunction

    function automatic longint membrane_substep(longint v, longint u, longint cur, longint lin,
                                                longint off, longint stp);
        longint t;
        t = clamp32(qmul(K_004, v) + lin);
        t = qmul(t, v);
        t = clamp32(t + off);
        t = clamp32(t - u);
        t = clamp32(t + cur);
        return clamp32(v + qmul(stp, t));
    endfunction

    function automatic neuron_out_t advance_neuron(neuron_req_t req);
        neuron_out_t res;
        longint a, b, c, d, v, u, cur;
        res.spiked = 1'b0;
        if (req.action == ACT_INIT)
        begin
            case (model_kind)
                KIND_TONIC:      begin model_v = -70 * Q_ONE; model_u = -14 * Q_ONE; end
                KIND_PHASIC:     begin model_v = -64 * Q_ONE; model_u = -16 * Q_ONE; end
                KIND_INTEGRATOR: begin model_v = -60 * Q_ONE; model_u = 6 * Q_ONE; end
                default:         begin model_v = -64 * Q_ONE; model_u = -838861; end
            endcase
        end
        else
        begin
            cur = longint'($signed(req.current));
            a = K_002;
            b = K_02;
            c = -65 * Q_ONE;
            d = 6 * Q_ONE;
            case (model_kind)
                KIND_PHASIC:
                    b = K_QUARTER;
                KIND_INTEGRATOR:
                begin
                    b = -K_01;
                    c = -55 * Q_ONE;
                end
                KIND_GENERIC:
                begin
                    b = K_QUARTER;
                    if (!model_exc)
                    begin
                        a = K_01;
                        d = 2 * Q_ONE;
                    end
                end
                default: ;
            endcase
            v = model_v;
            u = model_u;
            if (v >= FIRE_LEVEL)
            begin
                v = c;
                u = clamp32(u + d);
                res.spiked = 1'b1;
            end
            if (model_kind == KIND_INTEGRATOR)
                repeat (4) v = membrane_substep(v, u, cur, K_4_1, K_108, K_QUARTER);
            else
                repeat (2) v = membrane_substep(v, u, cur, K_5, K_140, K_HALF);
            u = clamp32(u + qmul(a, clamp32(qmul(b, v) - u)));
            model_v = v;
            model_u = u;
        end
        res.membrane = model_v[31:0];
        res.recovery = model_u[31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < 40)
            $display("mismatch in %s: got %h, want %h", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                due_outputs.push_back(advance_neuron('{s_axis_tuser, s_axis_tdata}));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (queued_requests.size() > 0)
                begin
                    neuron_req_t req;
                    req = queued_requests.pop_front();
                    s_axis_tuser  <= req.action;
                    s_axis_tdata  <= req.current;
                    s_axis_tvalid <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 8);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_NEURON_KIND)
                    model_kind = cfg_data[1:0];
                else
                    model_exc = cfg_data[0];
                writes_applied++;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (queued_writes.size() > 0)
                begin
                    reg_write_t w;
                    w = queued_writes.pop_front();
                    cfg_index <= w.index;
                    cfg_data  <= w.data;
                    cfg_valid <= 1'b1;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_outputs.size() == 0)
                    report_mismatch("unpredicted output", m_axis_tdata[31:0], '0);
                else
                begin
                    neuron_out_t want;
                    want = due_outputs.pop_front();
                    if (m_axis_tuser !== want.spiked)
                        report_mismatch("spiked", 32'(m_axis_tuser), 32'(want.spiked));
                    if (m_axis_tdata[31:0] !== want.membrane)
                        report_mismatch("membrane", m_axis_tdata[31:0], want.membrane);
                    if (m_axis_tdata[63:32] !== want.recovery)
                        report_mismatch("recovery", m_axis_tdata[63:32], want.recovery);
                end
                outputs_checked++;
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    sink_gap = $urandom_range(1, 8);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[spiking_neuron_step] ERROR");
            $finish;
        end
    end

    task automatic send(logic action, logic [31:0] current);
        queued_requests.push_back('{action, current});
        requests_issued++;
    endtask

    task automatic settle();
        while (outputs_checked < requests_issued)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        settle();
        queued_writes.push_back('{index, data});
        writes_issued++;
        while (writes_applied < writes_issued)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_current();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 32'(int'($urandom_range(0, 50 * Q)) - 10 * Q);
        if (sel < 75)
            return 32'(int'($urandom_range(0, 400 * Q)) - 200 * Q);
        if (sel < 90)
            return $urandom;
        if (sel < 95)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h7fffffff;
                1:       return 32'h80000000;
                2:       return 32'hffffffff;
                default: return 32'h0;
            endcase
        end
        return 32'h0;
    endfunction

    initial
    begin : stimulus
        int phase;
        int k;
        logic [1:0] kind;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send(ACT_TICK, 32'h0);
        send(ACT_TICK, 32'h7fffffff);
        send(ACT_TICK, 32'h80000000);
        send(ACT_TICK, 32'hffffffff);
        send(ACT_INIT, 32'hffffffff);
        repeat (3) send(ACT_TICK, 32'(10 * Q));

        write_reg(CFG_NEURON_KIND, KIND_PHASIC);
        send(ACT_INIT, 32'h0);
        repeat (2) send(ACT_TICK, 32'(20 * Q));

        write_reg(CFG_NEURON_KIND, KIND_INTEGRATOR);
        send(ACT_TICK, 32'(5 * Q));
        send(ACT_INIT, 32'h12345678);
        repeat (2) send(ACT_TICK, 32'(30 * Q));
        send(ACT_TICK, 32'h7fffffff);

        write_reg(CFG_NEURON_KIND, KIND_GENERIC);
        write_reg(CFG_EXCITATORY, 2'd0);
        send(ACT_INIT, 32'h0);
        send(ACT_TICK, 32'h7fffffff);
        send(ACT_TICK, 32'h0);
        send(ACT_TICK, 32'h80000000);

        write_reg(CFG_EXCITATORY, 2'd3);
        send(ACT_TICK, 32'h7fffffff);
        send(ACT_TICK, 32'h0);

        for (phase = 0; phase < 10; phase++)
        begin
            if (phase == 8)
                idle_on = 1'b0;
            kind = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
            write_reg(CFG_NEURON_KIND, kind);
            write_reg(CFG_EXCITATORY, (phase < 4) ? 2'(phase % 2) : 2'($urandom_range(0, 3)));
            if ($urandom_range(0, 3) != 0)
                send(ACT_INIT, $urandom);
            for (k = 0; k < 100; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send(ACT_INIT, $urandom);
                else
                    send(ACT_TICK, pick_current());
            end
        end

        settle();
        repeat (80) @(posedge clk);
        if (due_outputs.size() != 0)
            report_mismatch("outputs never delivered", 32'(due_outputs.size()), '0);
        if (mismatch_count == 0)
            $display("[spiking_neuron_step] OK");
        else
            $display("[spiking_neuron_step] ERROR");
        $finish;
    end

endmodule
